[design/swft_pkg.sv]
// ----------------------------------------------------------------------------
// swft_pkg
// Shared types and constants of the sequence window and fragment tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package swft_pkg;

	localparam int SEQ_W  = 16;
	localparam int AGE_W  = 8;
	localparam int FIDX_W = 8;

	typedef enum logic [1:0] {
		ST_REJECTED = 2'd0,
		ST_IGNORED  = 2'd1,
		ST_ACCEPTED = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_CHAIN,
		S_REL,
		S_OUT
	} fsm_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic chain_step;
		logic rel_step;
	} cmd_t;

	typedef struct packed {
		logic need_walk;
		logic chain_end;
		logic chain_ok;
		logic rel_end;
	} stat_t;

endpackage

`default_nettype wire

[design/swft_ctrl.sv]
// ----------------------------------------------------------------------------
// swft_ctrl
// Sequencer: capture, evaluate, chain check walk, release walk, result.
// ----------------------------------------------------------------------------
`default_nettype none

module swft_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire swft_pkg::stat_t st,
	output swft_pkg::cmd_t      cmd
);
	import swft_pkg::*;

	fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_valid) state_d = S_EVAL;
			S_EVAL:  state_d = st.need_walk ? S_CHAIN : S_OUT;
			S_CHAIN: if (st.chain_end) state_d = st.chain_ok ? S_REL : S_OUT;
			S_REL:   if (st.rel_end) state_d = S_OUT;
			S_OUT:   if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_EVAL:  cmd.eval = 1'b1;
			S_CHAIN: cmd.chain_step = 1'b1;
			S_REL:   cmd.rel_step = 1'b1;
			S_OUT:   out_valid = 1'b1;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

[design/swft_dp.sv]
// ----------------------------------------------------------------------------
// swft_dp
// Window bitmap, newest number, reassembly slots, latched flags and result.
// ----------------------------------------------------------------------------
`default_nettype none

module swft_dp #(
	parameter int HISTORY_BITS = 64,
	parameter int FRAG_SLOTS   = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire swft_pkg::cmd_t            cmd,
	output swft_pkg::stat_t                st,
	input  wire logic                      command,
	input  wire logic                      header_valid,
	input  wire logic [swft_pkg::SEQ_W-1:0]  seq_num,
	input  wire logic                      is_retransmission,
	input  wire logic                      is_finished,
	input  wire logic                      is_continued,
	input  wire logic [swft_pkg::FIDX_W-1:0] frag_pos,
	output logic [1:0]                     status,
	output logic                           packet_ready,
	output logic [3:0]                     released_fragments,
	output logic [5:0]                     age_behind,
	output logic                           out_of_order,
	output logic                           flag_retransmission,
	output logic                           flag_finished,
	output logic                           flag_continued
);
	import swft_pkg::*;

	localparam int HB_W  = $clog2(HISTORY_BITS);
	localparam int IDX_W = (FRAG_SLOTS > 1) ? $clog2(FRAG_SLOTS) : 1;
	localparam int CNT_W = $clog2(FRAG_SLOTS + 1);

	// Captured request.
	logic              cmd_q, hv_q, retr_q, fin_q, cont_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [FIDX_W-1:0] fidx_q;

	logic [HISTORY_BITS-1:0] bitmap_q;
	logic [SEQ_W-1:0]        newest_q;
	logic [AGE_W-1:0]        age_q   [FRAG_SLOTS];
	logic [FRAG_SLOTS-1:0]   valid_q;
	logic [FRAG_SLOTS-1:0]   scont_q;
	logic                    ready_q;
	logic                    f_retr_q, f_fin_q, f_cont_q, f_ooo_q;

	status_t          status_q;
	logic [5:0]       pkt_age_q;
	logic [CNT_W-1:0] rel_cnt_q;

	// Walk registers.
	logic [IDX_W-1:0] walk_q;
	logic             ok_q;
	logic             prev_valid_q;
	logic [AGE_W-1:0] prev_age_q;

	// Window evaluation.
	logic [SEQ_W-1:0]      diff, mag, new_newest;
	logic                  first, neg, newer, ignored, fin_rej, frag, frag_rej, stale;
	logic [5:0]            age_v;
	logic [HISTORY_BITS-1:0] bm_next;
	logic [IDX_W-1:0]      fi;
	logic [AGE_W:0]        aged      [FRAG_SLOTS];
	logic [FRAG_SLOTS-1:0] aged_valid;

	always_comb begin
		first      = (bitmap_q == '0);
		diff       = seq_q - newest_q;
		neg        = diff[SEQ_W-1];
		mag        = neg ? (~diff + 1'b1) : diff;
		newer      = !first && !neg && (diff != '0);
		ignored    = !first && ((mag >= SEQ_W'(HISTORY_BITS)) || (neg && retr_q) ||
			(!newer && bitmap_q[mag[HB_W-1:0]]));
		age_v      = (first || newer) ? 6'd0 : 6'(mag);
		new_newest = (first || newer) ? seq_q : newest_q;
		if (first) begin
			bm_next = HISTORY_BITS'(1);
		end else if (newer) begin
			bm_next = (bitmap_q << diff[HB_W-1:0]) | HISTORY_BITS'(1);
		end else begin
			bm_next = bitmap_q | (HISTORY_BITS'(1) << mag[HB_W-1:0]);
		end
		for (int k = 0; k < FRAG_SLOTS; k++) begin
			aged[k]       = newer ? ({1'b0, age_q[k]} + (AGE_W+1)'(diff[HB_W-1:0]))
				: {1'b0, age_q[k]};
			aged_valid[k] = valid_q[k] && (aged[k] <= (AGE_W+1)'(HISTORY_BITS));
		end
		fin_rej  = fin_q && (new_newest != seq_q);
		frag     = (fidx_q != '0) || cont_q;
		frag_rej = fidx_q >= FIDX_W'(FRAG_SLOTS);
		fi       = fidx_q[IDX_W-1:0];
		stale    = aged_valid[fi] && ((AGE_W+1)'(age_v) > aged[fi]);
	end

	// Walk status.
	logic             last_idx;
	logic             chain_ok_n;
	logic             rel_hit;
	logic [AGE_W:0]   cur_inc;

	always_comb begin
		last_idx   = (walk_q == IDX_W'(FRAG_SLOTS - 1));
		cur_inc    = {1'b0, age_q[walk_q]} + 1'b1;
		chain_ok_n = ok_q && valid_q[walk_q] && ((walk_q == '0) ||
			(prev_valid_q && (cur_inc == {1'b0, prev_age_q})));
		rel_hit    = valid_q[walk_q] && ((walk_q == '0) || (cur_inc == {1'b0, prev_age_q}));
		st.need_walk = !cmd_q && hv_q && !ignored && !fin_rej && frag && !frag_rej && !stale;
		st.chain_end = !scont_q[walk_q] || last_idx;
		st.chain_ok  = chain_ok_n;
		st.rel_end   = !rel_hit || last_idx;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q  <= command;
			hv_q   <= header_valid;
			seq_q  <= seq_num;
			retr_q <= is_retransmission;
			fin_q  <= is_finished;
			cont_q <= is_continued;
			fidx_q <= frag_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitmap_q     <= '0;
			newest_q     <= '0;
			for (int k = 0; k < FRAG_SLOTS; k++) begin
				age_q[k] <= '0;
			end
			valid_q      <= '0;
			scont_q      <= '0;
			ready_q      <= 1'b0;
			f_retr_q     <= 1'b0;
			f_fin_q      <= 1'b0;
			f_cont_q     <= 1'b0;
			f_ooo_q      <= 1'b0;
			walk_q       <= '0;
			ok_q         <= 1'b0;
			prev_valid_q <= 1'b0;
			prev_age_q   <= '0;
			status_q     <= ST_REJECTED;
			pkt_age_q    <= '0;
			rel_cnt_q    <= '0;
		end else if (cmd.eval) begin
			status_q     <= ST_REJECTED;
			pkt_age_q    <= '0;
			rel_cnt_q    <= '0;
			walk_q       <= '0;
			ok_q         <= 1'b1;
			prev_valid_q <= 1'b0;
			if (cmd_q) begin
				ready_q <= 1'b0;
			end else if (hv_q) begin
				if (ignored) begin
					status_q <= ST_IGNORED;
				end else begin
					bitmap_q <= bm_next;
					newest_q <= new_newest;
					if (newer) begin
						for (int k = 0; k < FRAG_SLOTS; k++) begin
							age_q[k] <= aged[k][AGE_W-1:0];
						end
						valid_q <= aged_valid;
					end
					if (!fin_rej) begin
						ready_q <= 1'b1;
						// An out of range fragment index is rejected with flags kept.
						if (!(frag && frag_rej)) begin
							status_q  <= ST_ACCEPTED;
							pkt_age_q <= age_v;
							f_retr_q  <= retr_q;
							f_fin_q   <= fin_q;
							f_cont_q  <= cont_q;
							f_ooo_q   <= new_newest > seq_q;
							if (frag) begin
								if (stale) begin
									ready_q <= 1'b0;
								end else begin
									age_q[fi]   <= AGE_W'(age_v);
									valid_q[fi] <= 1'b1;
									scont_q[fi] <= cont_q;
								end
							end
						end
					end
				end
			end
		end else if (cmd.chain_step) begin
			ok_q         <= chain_ok_n;
			prev_valid_q <= valid_q[walk_q];
			prev_age_q   <= age_q[walk_q];
			walk_q       <= walk_q + 1'b1;
			if (st.chain_end) begin
				walk_q <= '0;
				if (!chain_ok_n) ready_q <= 1'b0;
			end
		end else if (cmd.rel_step) begin
			walk_q <= walk_q + 1'b1;
			if (rel_hit) begin
				valid_q[walk_q] <= 1'b0;
				prev_age_q      <= age_q[walk_q];
				rel_cnt_q       <= rel_cnt_q + 1'b1;
			end
		end
	end

	assign status              = status_q;
	assign packet_ready        = ready_q;
	assign released_fragments  = 4'(rel_cnt_q);
	assign age_behind          = pkt_age_q;
	assign out_of_order        = f_ooo_q;
	assign flag_retransmission = f_retr_q;
	assign flag_finished       = f_fin_q;
	assign flag_continued      = f_cont_q;

endmodule

`default_nettype wire

[design/seq_window_fragment_tracker.sv]
// ----------------------------------------------------------------------------
// seq_window_fragment_tracker
// Receive-side replay window and fragment reassembly tracker.
// ----------------------------------------------------------------------------
// One request is handled at a time. It is taken in an idle cycle and evaluated in
// the next cycle. For a take command, a rejected or ignored header, or a packet
// that is not a fragment, its result is shown from the cycle after that. A stored
// fragment adds a chain check walk and, if the chain is complete, a release walk
// over the reassembly slots, each one slot per cycle. The result is held until it
// is taken, and the next request is accepted in the cycle after that.
`default_nettype none

module seq_window_fragment_tracker #(
	parameter int HISTORY_BITS = 64,
	parameter int FRAG_SLOTS   = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        command,
	input  wire logic        header_valid,
	input  wire logic [15:0] seq_num,
	input  wire logic        is_retransmission,
	input  wire logic        is_finished,
	input  wire logic        is_continued,
	input  wire logic [7:0]  frag_pos,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic             packet_ready,
	output logic [3:0]       released_fragments,
	output logic [5:0]       age_behind,
	output logic             out_of_order,
	output logic             flag_retransmission,
	output logic             flag_finished,
	output logic             flag_continued
);
	import swft_pkg::*;

	cmd_t  cmd;
	stat_t st;

	swft_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	swft_dp #(
		.HISTORY_BITS (HISTORY_BITS),
		.FRAG_SLOTS   (FRAG_SLOTS)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.st                  (st),
		.command             (command),
		.header_valid        (header_valid),
		.seq_num             (seq_num),
		.is_retransmission   (is_retransmission),
		.is_finished         (is_finished),
		.is_continued        (is_continued),
		.frag_pos            (frag_pos),
		.status              (status),
		.packet_ready        (packet_ready),
		.released_fragments  (released_fragments),
		.age_behind          (age_behind),
		.out_of_order        (out_of_order),
		.flag_retransmission (flag_retransmission),
		.flag_finished       (flag_finished),
		.flag_continued      (flag_continued)
	);

endmodule

`default_nettype wire

[design/swft_checker.sv]
// ----------------------------------------------------------------------------
// swft_checker
// Port-level checks of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module swft_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] status,
	input wire logic [3:0] released_fragments,
	input wire logic [5:0] age_behind
);
	import swft_pkg::*;

	// Only one request is in flight, so the two sides never open together.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result is shown");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("stalled result changed");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("unknown status code");

	// Age and released count belong to accepted packets only.
	a_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_ACCEPTED |-> released_fragments == 4'd0 &&
		age_behind == 6'd0)
		else $error("age or release on a packet not accepted");

	// A taken result is followed by a cycle with the input side open.
	a_return: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready)
		else $error("input side not reopened");

endmodule

bind seq_window_fragment_tracker swft_checker u_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_ready           (in_ready),
	.out_valid          (out_valid),
	.out_ready          (out_ready),
	.status             (status),
	.released_fragments (released_fragments),
	.age_behind         (age_behind)
);

`default_nettype wire
